// ----- design/gblc_pkg.sv -----
// ----------------------------------------------------------------------------
// gblc_pkg
// Shared types, constants and helpers for the grey box logo compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package gblc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_BORDER_WIDTH = 3;
    localparam int DEF_COORD_BITS   = 12;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BOX_LEFT   = 2'd0,
        CFG_BOX_RIGHT  = 2'd1,
        CFG_BOX_TOP    = 2'd2,
        CFG_BOX_BOTTOM = 2'd3
    } cfg_index_t;

    // BT.709 luma weights, unsigned 0.16, summing to 65536
    localparam logic [15:0] LUMA_W_R = 16'd13933;
    localparam logic [15:0] LUMA_W_G = 16'd46871;
    localparam logic [15:0] LUMA_W_B = 16'd4732;

    localparam logic [7:0] CHAN_FULL = 8'hFF;
    localparam logic [7:0] CHAN_ZERO = 8'h00;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Logo pixel packed red 23:16, green 15:8, blue 7:0
    function automatic rgb_t unpack_rgb(input logic [23:0] packed_rgb);
        rgb_t px;
        px.r = packed_rgb[23:16];
        px.g = packed_rgb[15:8];
        px.b = packed_rgb[7:0];
        return px;
    endfunction

    // True when no channel is at full scale (full-scale channels are keyed out)
    function automatic logic no_white(input rgb_t px);
        return (px.r != CHAN_FULL) && (px.g != CHAN_FULL) && (px.b != CHAN_FULL);
    endfunction

endpackage

`default_nettype wire

// ----- design/gblc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gblc_cfg_regs
// Highlight box coordinate registers behind the configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gblc_cfg_regs import gblc_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_data,
    output logic [COORD_BITS-1:0]      box_left,
    output logic [COORD_BITS-1:0]      box_right,
    output logic [COORD_BITS-1:0]      box_top,
    output logic [COORD_BITS-1:0]      box_bottom
);

    logic [COORD_BITS-1:0] left_reg, right_reg, top_reg, bottom_reg;
    cfg_index_t            idx;

    assign cfg_ready = 1'b1;
    assign idx       = cfg_index_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            right_reg  <= '0;
            top_reg    <= '0;
            bottom_reg <= '0;
        end else if (cfg_valid) begin
            unique case (idx)
                CFG_BOX_LEFT:   left_reg   <= cfg_data;
                CFG_BOX_RIGHT:  right_reg  <= cfg_data;
                CFG_BOX_TOP:    top_reg    <= cfg_data;
                CFG_BOX_BOTTOM: bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign box_left   = left_reg;
    assign box_right  = right_reg;
    assign box_top    = top_reg;
    assign box_bottom = bottom_reg;

`ifndef NO_ASSERTIONS
    a_left_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && idx == CFG_BOX_LEFT) |=> (left_reg == $past(cfg_data)))
        else $error("box_left not taken from transfer");

    a_bottom_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && idx == CFG_BOX_BOTTOM) |=> (bottom_reg == $past(cfg_data)))
        else $error("box_bottom not taken from transfer");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_valid |=> ($stable(left_reg) && $stable(right_reg)
                        && $stable(top_reg) && $stable(bottom_reg)))
        else $error("box register changed without a transfer");
`endif

endmodule

`default_nettype wire

// ----- design/gblc_compose.sv -----
// ----------------------------------------------------------------------------
// gblc_compose
// Priority compositing of one pixel: second logo, first logo, box border,
// grey outside the box, else pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module gblc_compose import gblc_pkg::*; #(
    parameter int BORDER_WIDTH = DEF_BORDER_WIDTH,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    input  wire rgb_t                  photo,
    input  wire logic                  first_logo_present,
    input  wire logic [23:0]           first_logo_rgb,
    input  wire logic                  second_logo_present,
    input  wire logic [23:0]           second_logo_rgb,
    input  wire logic [COORD_BITS-1:0] box_left,
    input  wire logic [COORD_BITS-1:0] box_right,
    input  wire logic [COORD_BITS-1:0] box_top,
    input  wire logic [COORD_BITS-1:0] box_bottom,
    output rgb_t                       pix_out
);

    localparam logic [COORD_BITS:0] BW_EXT = (COORD_BITS + 1)'(BORDER_WIDTH);

    rgb_t                logo1, logo2;
    logic [COORD_BITS:0] x_ext, y_ext;
    logic [COORD_BITS:0] left_lim, top_lim, x_plus_bw, y_plus_bw;
    logic                x_half, y_half, near_top, near_bot, near_left, near_right;
    logic                on_border, inside_box;
    logic [23:0]         grey_sum;
    logic [7:0]          grey;

    assign logo1 = unpack_rgb(first_logo_rgb);
    assign logo2 = unpack_rgb(second_logo_rgb);

    // One extra bit so that edge + width never wraps; b - w < y is y + w > b
    assign x_ext     = {1'b0, pos_x};
    assign y_ext     = {1'b0, pos_y};
    assign left_lim  = {1'b0, box_left} + BW_EXT;
    assign top_lim   = {1'b0, box_top}  + BW_EXT;
    assign x_plus_bw = x_ext + BW_EXT;
    assign y_plus_bw = y_ext + BW_EXT;

    // Half-open spans: border edges stop one short of right/bottom
    assign x_half     = (pos_x >= box_left) && (pos_x < box_right);
    assign y_half     = (pos_y >= box_top)  && (pos_y < box_bottom);
    assign near_top   = (pos_y >= box_top)  && (y_ext < top_lim);
    assign near_bot   = (y_plus_bw > {1'b0, box_bottom}) && (pos_y <= box_bottom);
    assign near_left  = (pos_x >= box_left) && (x_ext < left_lim);
    assign near_right = (x_plus_bw > {1'b0, box_right}) && (pos_x <= box_right);

    assign on_border  = (x_half && (near_top || near_bot))
                     || (y_half && (near_left || near_right));
    assign inside_box = (pos_x >= box_left) && (pos_x <= box_right)
                     && (pos_y >= box_top) && (pos_y <= box_bottom);

    // Weights sum to 1.0, so the integer part never exceeds 255
    assign grey_sum = (24'(LUMA_W_R) * 24'(photo.r)) + (24'(LUMA_W_G) * 24'(photo.g))
                    + (24'(LUMA_W_B) * 24'(photo.b));
    assign grey     = grey_sum[23:16];

    always_comb begin
        if (second_logo_present && no_white(logo2)) begin
            pix_out = '{r: CHAN_FULL, g: logo2.g, b: CHAN_FULL};
        end else if (first_logo_present && no_white(logo1)) begin
            pix_out = logo1;
        end else if (on_border) begin
            pix_out = '{r: CHAN_ZERO, g: CHAN_FULL, b: CHAN_FULL};
        end else if (!inside_box) begin
            pix_out = '{r: grey, g: grey, b: grey};
        end else begin
            pix_out = photo;
        end
    end

endmodule

`default_nettype wire

// ----- design/grayscale_box_logo_compositor.sv -----
// ----------------------------------------------------------------------------
// grayscale_box_logo_compositor
// Composites photo pixels with two pre-placed logos and a highlight box.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one pixel per transfer; tdata carries coordinates, photo RGB and
//   both logo pixels, tuser carries the two logo present flags.
//   m_axis: one composited RGB pixel per input pixel, in order.
//   cfg: write channel for the box edges (left, right, top, bottom), always
//   ready; write only while no pixels are in flight.
// Timing:
//   Two register stages (input register, result register): an accepted pixel is
//   registered in the input stage, composited, then registered in the result
//   stage, which drives m_tvalid. One pixel a cycle is sustained while m_tready
//   stays high; the compositing logic between the two stages is combinational.
// Reset (aresetn low, synchronous): both stages empty, box edges all zero.
// Stall: with m_tready low a full result register holds; the input register
//   still fills, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module grayscale_box_logo_compositor import gblc_pkg::*; #(
    parameter int BORDER_WIDTH = DEF_BORDER_WIDTH,
    parameter int COORD_BITS   = DEF_COORD_BITS,
    localparam int IN_BITS     = 2 * COORD_BITS + 72,
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // pos_x, pos_y, pixel_r, pixel_g, pixel_b, first_logo_rgb, second_logo_rgb
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // first_logo_present, second_logo_present
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // out_r, out_g, out_b
    output logic [23:0]                m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_data
);

    localparam int CB = COORD_BITS;

    logic [COORD_BITS-1:0] box_left, box_right, box_top, box_bottom;

    logic               in_valid_reg;
    logic [IN_BITS-1:0] in_data_reg;
    logic [1:0]         in_user_reg;
    logic               out_valid_reg;
    rgb_t               out_pix_reg;
    rgb_t               pix_next;
    rgb_t               photo;
    logic               out_load, in_load;

    gblc_cfg_regs #(
        .COORD_BITS(COORD_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .box_left  (box_left),
        .box_right (box_right),
        .box_top   (box_top),
        .box_bottom(box_bottom)
    );

    // Result stage frees when empty or being taken; input stage then advances
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
            in_user_reg <= s_tuser;
        end
    end

    assign photo = '{r: in_data_reg[2*CB +: 8],
                     g: in_data_reg[2*CB+8 +: 8],
                     b: in_data_reg[2*CB+16 +: 8]};

    gblc_compose #(
        .BORDER_WIDTH(BORDER_WIDTH),
        .COORD_BITS  (COORD_BITS)
    ) u_compose (
        .pos_x              (in_data_reg[0 +: CB]),
        .pos_y              (in_data_reg[CB +: CB]),
        .photo              (photo),
        .first_logo_present (in_user_reg[0]),
        .first_logo_rgb     (in_data_reg[2*CB+24 +: 24]),
        .second_logo_present(in_user_reg[1]),
        .second_logo_rgb    (in_data_reg[2*CB+48 +: 24]),
        .box_left           (box_left),
        .box_right          (box_right),
        .box_top            (box_top),
        .box_bottom         (box_bottom),
        .pix_out            (pix_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_pix_reg <= pix_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg.b, out_pix_reg.g, out_pix_reg.r};

`ifndef NO_ASSERTIONS
    a_in_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        in_load |=> in_valid_reg)
        else $error("accepted pixel not held in input stage");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load) |=> out_valid_reg)
        else $error("pixel lost between stages");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_load) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input stage overwritten while blocked");
`endif

endmodule

`default_nettype wire
